FILE: rtl/ils_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants of the indexed list store
// Holds the sizing constants, the request and status codes and the control
// bundle passed from the decoder to the entry store.
// ----------------------------------------------------------------------------
package ils_pkg;

	// Sizing of the store.
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;

	// Fixed field widths of the request and result transfers.
	localparam int VALUE_W = 32;
	localparam int POS_W   = 5;
	localparam int COUNT_W = 5;

	// Derived internal widths.
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_BACK  = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_INSERT     = 3'd4,
		FN_REMOVE     = 3'd5,
		FN_READ       = 3'd6,
		FN_CLEAR      = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef logic [DATA_WIDTH-1:0] word_t;

	// Decoded request: what the store has to do with the entries.
	typedef struct packed {
		status_t          status;
		logic             put;
		logic             take;
		logic             rd;
		logic [IDX_W-1:0] idx;
		logic [CNT_W-1:0] next_count;
	} ctl_t;

	// Sign-extends (or truncates) a stored word to the result width.
	function automatic logic signed [VALUE_W-1:0] widen(input word_t w);
		logic signed [DATA_WIDTH-1:0] ws;
		ws = $signed(w);
		return VALUE_W'(ws);
	endfunction

endpackage

FILE: rtl/ils_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_if: request and response channels of the indexed list store
// Valid/ready channels; a transfer takes place when both are high at a clock
// edge.
// ----------------------------------------------------------------------------
interface ils_req_if
	import ils_pkg::*;
();
	logic                       valid;
	logic                       ready;
	func_t                      func;
	logic signed [VALUE_W-1:0]  value;
	logic        [POS_W-1:0]    position;

	modport source (output valid, func, value, position, input ready);
	modport sink   (input valid, func, value, position, output ready);
endinterface

interface ils_rsp_if
	import ils_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [VALUE_W-1:0]  read_value;
	logic        [COUNT_W-1:0]  count;
	status_t                    status;

	modport source (output valid, read_value, count, status, input ready);
	modport sink   (input valid, read_value, count, status, output ready);
endinterface

FILE: rtl/ils_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_decode: request decoder
// Checks a request against the current entry count and works out the status,
// the position to act on and the count after the request.
// ----------------------------------------------------------------------------
module ils_decode
	import ils_pkg::*;
(
	input  func_t            func,
	input  logic [POS_W-1:0] position,
	input  logic [CNT_W-1:0] count,
	output ctl_t             ctl
);

	logic             full;
	logic             empty;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	logic [IDX_W-1:0] pos_idx;
	logic [IDX_W-1:0] last_idx;
	logic [IDX_W-1:0] end_idx;

	assign full     = (count == CNT_W'(CAPACITY));
	assign empty    = (count == '0);
	assign pos_c    = CMP_W'(position);
	assign cnt_c    = CMP_W'(count);
	assign pos_idx  = pos_c[IDX_W-1:0];
	assign end_idx  = cnt_c[IDX_W-1:0];
	assign last_idx = end_idx - IDX_W'(1);

	always_comb begin
		ctl            = '0;
		ctl.status     = ST_OK;
		ctl.next_count = count;
		unique case (func)
			FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT: begin
				if (full) begin
					ctl.status = ST_FULL;
				end else if (func == FN_INSERT && pos_c > cnt_c) begin
					ctl.status = ST_RANGE;
				end else begin
					ctl.put        = 1'b1;
					ctl.next_count = count + CNT_W'(1);
					if (func == FN_PUSH_FRONT) begin
						ctl.idx = '0;
					end else if (func == FN_PUSH_BACK) begin
						ctl.idx = end_idx;
					end else begin
						ctl.idx = pos_idx;
					end
				end
			end
			FN_POP_FRONT, FN_POP_BACK, FN_REMOVE, FN_READ: begin
				if (empty) begin
					ctl.status = ST_EMPTY;
				end else if ((func == FN_REMOVE || func == FN_READ) && pos_c >= cnt_c) begin
					ctl.status = ST_RANGE;
				end else begin
					ctl.rd = 1'b1;
					if (func == FN_POP_FRONT) begin
						ctl.idx = '0;
					end else if (func == FN_POP_BACK) begin
						ctl.idx = last_idx;
					end else begin
						ctl.idx = pos_idx;
					end
					if (func != FN_READ) begin
						ctl.take       = 1'b1;
						ctl.next_count = count - CNT_W'(1);
					end
				end
			end
			FN_CLEAR: begin
				ctl.next_count = '0;
			end
			default: begin
				ctl.next_count = count;
			end
		endcase
	end

endmodule

FILE: rtl/ils_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_store: entry register array and entry count
// Every entry loads from its neighbour below or above, so an insert or a
// remove shifts the whole tail in a single update of the array.
// ----------------------------------------------------------------------------
module ils_store
	import ils_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ctl_t             ctl,
	input  word_t            wdata,
	output logic [CNT_W-1:0] count,
	output word_t            rdata
);

	word_t            entry_q [CAPACITY];
	word_t            entry_d [CAPACITY];
	word_t            from_below [CAPACITY];
	word_t            from_above [CAPACITY];
	logic [CNT_W-1:0] count_q;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_nb
		if (g == 0) begin : g_first
			assign from_below[g] = wdata;
		end else begin : g_rest
			assign from_below[g] = entry_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign from_above[g] = entry_q[g];
		end else begin : g_body
			assign from_above[g] = entry_q[g+1];
		end

		always_comb begin
			entry_d[g] = entry_q[g];
			if (ctl.put) begin
				if (IDX_W'(g) == ctl.idx) begin
					entry_d[g] = wdata;
				end else if (IDX_W'(g) > ctl.idx) begin
					entry_d[g] = from_below[g];
				end
			end else if (ctl.take && IDX_W'(g) >= ctl.idx) begin
				entry_d[g] = from_above[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				entry_q[g] <= entry_d[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= ctl.next_count;
		end
	end

	assign count = count_q;
	assign rdata = entry_q[ctl.idx];

endmodule

FILE: rtl/indexed_list_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_core: bounded ordered list of signed words
// Push, pop, insert, remove, read and clear on a list of up to CAPACITY
// entries, one request per transfer and one result per request.
// ----------------------------------------------------------------------------
// Path: a request passes through the request register and then the result
// register before its result is shown on rsp.
// Throughput: one request per cycle while rsp is taken; the entry array
// and the count are updated in the single cycle a request leaves its register.
// Reset: arst_n clears the valid flags and the entry count at once; the
// entry words themselves are not reset, as no entry at or above count is read.
// ----------------------------------------------------------------------------
module indexed_list_store_core
	import ils_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	ils_req_if.sink  req,
	ils_rsp_if.source rsp
);

	// Request register. A request sits here while it is decoded against the
	// current count, and it is applied to the entry array as it moves on.
	logic                  valid_s1;
	func_t                 func_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic [POS_W-1:0]      position_s1;

	// Result register, decoupling the request side from a stalled consumer.
	logic                  rsp_valid_q;
	logic signed [VALUE_W-1:0] read_value_q;
	logic [COUNT_W-1:0]    count_q;
	status_t               status_q;

	logic                  advance;
	ctl_t                  ctl;
	logic [CNT_W-1:0]      count;
	word_t                 rdata;

	// The request in the register moves on whenever the result register is
	// free or is being emptied in the same cycle; the request register then
	// takes a new transfer at the same edge.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			func_s1     <= req.func;
			value_s1    <= req.value;
			position_s1 <= req.position;
		end
	end

	ils_decode u_decode (
		.func     (func_s1),
		.position (position_s1),
		.count    (count),
		.ctl      (ctl)
	);

	// The array is only touched by a request that is actually leaving the
	// request register, so a stalled result never sees its state applied twice.
	ils_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.ctl    (ctl),
		.wdata  (DATA_WIDTH'(value_s1)),
		.count  (count),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// The read value is the entry at the selected position taken before the
	// update; it is zero for pushes, inserts, clears and any refused request.
	always_ff @(posedge clk) begin
		if (advance) begin
			read_value_q <= ctl.rd ? widen(rdata) : '0;
			count_q      <= COUNT_W'(ctl.next_count);
			status_q     <= ctl.status;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.count      = count_q;
	assign rsp.status     = status_q;

endmodule

FILE: rtl/ils_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_checker: port-level checks of the indexed list store
// Watches the result channel for results that contradict each other.
// ----------------------------------------------------------------------------
module ils_checker
	import ils_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rsp_valid,
	input  logic                      rsp_ready,
	input  logic signed [VALUE_W-1:0] rsp_read_value,
	input  logic [COUNT_W-1:0]        rsp_count,
	input  status_t                   rsp_status
);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_count <= COUNT_W'(CAPACITY)))
		else $error("result count above capacity");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != ST_OK) |-> (rsp_read_value == '0))
		else $error("refused request returned a non-zero value");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == ST_FULL) |-> (rsp_count == COUNT_W'(CAPACITY)))
		else $error("full status with list not full");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_count == '0))
		else $error("empty status with entries present");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_value)
			&& $stable(rsp_count) && $stable(rsp_status)))
		else $error("stalled result changed");

endmodule

bind indexed_list_store_core ils_checker u_ils_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value),
	.rsp_count      (rsp.count),
	.rsp_status     (rsp.status)
);

FILE: bench/indexed_list_store_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_core_tb: self-checking bench for the indexed list store
// Drives list requests over the request channel and keeps a shadow copy of
// the list. Every response transfer is compared field by field with the
// result that the shadow copy predicts. The run opens with directed requests
// on an empty, a part-filled and a full list, then moves to random traffic
// with random idling on both channels. It ends with a clean stretch that has
// no idling at all.
// ----------------------------------------------------------------------------
module indexed_list_store_core_tb;
	import ils_pkg::*;

	// One predicted response, kept at the widths of the response channel.
	typedef struct {
		logic signed [VALUE_W-1:0] read_value;
		logic        [COUNT_W-1:0] count;
		status_t                   status;
	} list_result_t;

	logic clk;
	logic arst_n;

	ils_req_if req_ch ();
	ils_rsp_if rsp_ch ();

	indexed_list_store_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the list. Only positions below shadow_count are ever
	// looked at, so the words above it need no reset value.
	word_t        shadow_entries [CAPACITY];
	int           shadow_count;
	list_result_t pending_results [$];

	int failures;
	int requests_sent;
	int results_seen;
	int peak_count;
	int status_tally [4];
	int func_tally [8];

	// Idling controls. The receiver reads rsp_hold_cycles, counts the long
	// stall itself and puts the value back to zero once the stall is over.
	bit req_idle_en;
	bit rsp_idle_en;
	int rsp_hold_cycles;

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Applies one accepted request to the shadow list and returns the response
	// that the block must give for it. A rejected request leaves the list as
	// it was. Capacity is checked before position on the way in, and emptiness
	// before position on the way out.
	function automatic list_result_t apply_list_request(input func_t fn,
			input logic signed [VALUE_W-1:0] value, input logic [POS_W-1:0] position);
		list_result_t                 res;
		int                           at;
		int                           i;
		logic signed [DATA_WIDTH-1:0] taken;
		res.read_value = '0;
		res.status = ST_OK;
		at = 0;
		case (fn)
			FN_PUSH_FRONT, FN_PUSH_BACK, FN_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else if (fn == FN_INSERT && position > shadow_count) begin
					res.status = ST_RANGE;
				end else begin
					if (fn == FN_PUSH_BACK) begin
						at = shadow_count;
					end else if (fn == FN_INSERT) begin
						at = int'(position);
					end
					// Later entries move up one place to open the gap.
					for (i = shadow_count; i > at; i--) begin
						shadow_entries[i] = shadow_entries[i-1];
					end
					shadow_entries[at] = word_t'(value);
					shadow_count++;
				end
			end
			FN_POP_FRONT, FN_POP_BACK, FN_REMOVE, FN_READ: begin
				if (shadow_count == 0) begin
					res.status = ST_EMPTY;
				end else if (fn == FN_POP_BACK) begin
					at = shadow_count - 1;
				end else if (fn != FN_POP_FRONT) begin
					if (position >= shadow_count) begin
						res.status = ST_RANGE;
					end else begin
						at = int'(position);
					end
				end
				if (res.status == ST_OK) begin
					// The stored word is sign-extended to the result width.
					taken = shadow_entries[at];
					res.read_value = taken;
					if (fn != FN_READ) begin
						for (i = at; i + 1 < shadow_count; i++) begin
							shadow_entries[i] = shadow_entries[i+1];
						end
						shadow_count--;
					end
				end
			end
			default: begin
				// Clear always succeeds, even on an empty list.
				shadow_count = 0;
			end
		endcase
		res.count = COUNT_W'(shadow_count);
		return res;
	endfunction

	// Mostly uniform words, with the signed extremes, minus one and zero
	// mixed in often enough to appear many times in a run.
	function automatic logic signed [VALUE_W-1:0] random_word();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(VALUE_W-1){1'b0}}};
			1: return {1'b0, {(VALUE_W-1){1'b1}}};
			2: return '1;
			3: return '0;
			default: return $signed(VALUE_W'($urandom));
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Offers one request and holds it until the block takes the transfer. The
	// prediction is made at the accepting edge. After the transfer the sender
	// may drop valid for a random burst. Without a burst, valid stays high
	// so that the next request follows back to back.
	task automatic send_request(input func_t fn, input logic signed [VALUE_W-1:0] value,
			input logic [POS_W-1:0] position);
		list_result_t res;
		req_ch.valid    <= 1'b1;
		req_ch.func     <= fn;
		req_ch.value    <= value;
		req_ch.position <= position;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
		res = apply_list_request(fn, value, position);
		pending_results.push_back(res);
		requests_sent++;
		func_tally[fn]++;
		status_tally[res.status]++;
		if (shadow_count > peak_count) begin
			peak_count = shadow_count;
		end
		if (req_idle_en && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------------
	// Response side
	// ------------------------------------------------------------------------

	// The receiver either takes responses, idles for a short random burst, or
	// serves a long stall that a test has asked for.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (rsp_hold_cycles) @(posedge clk);
				rsp_hold_cycles = 0;
				rsp_ch.ready <= 1'b1;
			end else if (rsp_idle_en && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Every response transfer is matched against the oldest prediction. The
	// sampled values are those from before the edge, because all stimulus
	// and all block outputs change through nonblocking updates.
	always @(posedge clk) begin
		list_result_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("response with no request outstanding: read_value %0d count %0d status %0d",
					rsp_ch.read_value, rsp_ch.count, rsp_ch.status);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.read_value !== want.read_value) begin
					$error("read_value mismatch: expected %0d, actual %0d",
						want.read_value, rsp_ch.read_value);
					failures++;
				end
				if (rsp_ch.count !== want.count) begin
					$error("count mismatch: expected %0d, actual %0d", want.count, rsp_ch.count);
					failures++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d", want.status, rsp_ch.status);
					failures++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Every request that takes an entry out, and a read, on an empty list,
	// followed by a clear of the empty list.
	task automatic test_empty_list();
		send_request(FN_POP_FRONT, '0, '0);
		send_request(FN_POP_BACK, '0, '0);
		send_request(FN_REMOVE, '0, '0);
		send_request(FN_READ, '0, '0);
		send_request(FN_CLEAR, '0, '0);
	endtask

	// Both ends, an insert at the very end, an insert past the end, and reads
	// and removals inside and beyond the list. The stored words include the
	// signed extremes.
	task automatic test_edge_positions();
		send_request(FN_PUSH_FRONT, 32'sh8000_0000, '0);
		send_request(FN_PUSH_BACK, 32'sh7fff_ffff, 5'd31);
		send_request(FN_INSERT, '0, 5'd2);
		send_request(FN_INSERT, 32'sd1, 5'd5);
		send_request(FN_INSERT, -32'sd1, 5'd1);
		send_request(FN_READ, '0, 5'd3);
		send_request(FN_READ, '0, 5'd4);
		send_request(FN_REMOVE, '0, 5'd31);
		send_request(FN_REMOVE, '0, 5'd1);
		send_request(FN_POP_FRONT, '0, '0);
		send_request(FN_POP_BACK, '0, '0);
		send_request(FN_READ, '0, '0);
		send_request(FN_POP_FRONT, '0, '0);
	endtask

	// Fills the list to capacity. On a full list, all three kinds of push are
	// refused as full, and that check wins even for a bad position. One slot
	// is then freed, which makes an insert beyond the end a range error.
	task automatic test_full_list();
		int i;
		send_request(FN_CLEAR, '0, '0);
		for (i = 0; i < CAPACITY; i++) begin
			send_request(FN_PUSH_BACK, random_word(), '0);
		end
		send_request(FN_PUSH_FRONT, random_word(), '0);
		send_request(FN_PUSH_BACK, random_word(), '0);
		send_request(FN_INSERT, random_word(), 5'd31);
		send_request(FN_READ, '0, POS_W'(CAPACITY - 1));
		send_request(FN_REMOVE, '0, POS_W'(CAPACITY - 1));
		send_request(FN_INSERT, random_word(), POS_W'(CAPACITY));
		send_request(FN_INSERT, random_word(), POS_W'(CAPACITY - 1));
		send_request(FN_CLEAR, '0, '0);
	endtask

	// Random traffic. The mix swings between a growing and a shrinking bias,
	// so the fill level sweeps from empty to full and back again. Most
	// positions fall within the list or exactly at its end. The rest cover
	// the whole field, including values beyond the capacity.
	task automatic test_random_traffic(input int n_requests);
		int                 i;
		int                 pick;
		int                 swing;
		bit                 grow;
		func_t              fn;
		logic [POS_W-1:0]   position;
		grow = 1'($urandom_range(0, 1));
		swing = $urandom_range(20, 50);
		for (i = 0; i < n_requests; i++) begin
			if (--swing == 0) begin
				grow = !grow;
				swing = $urandom_range(20, 50);
			end
			pick = $urandom_range(0, 99);
			if (pick == 0) begin
				fn = FN_CLEAR;
			end else if (pick < 15) begin
				fn = FN_READ;
			end else if (pick < (grow ? 75 : 40)) begin
				case ($urandom_range(0, 2))
					0: fn = FN_PUSH_FRONT;
					1: fn = FN_PUSH_BACK;
					default: fn = FN_INSERT;
				endcase
			end else begin
				case ($urandom_range(0, 2))
					0: fn = FN_POP_FRONT;
					1: fn = FN_POP_BACK;
					default: fn = FN_REMOVE;
				endcase
			end
			if ($urandom_range(0, 6) == 0) begin
				position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
			end else begin
				position = POS_W'($urandom_range(0, shadow_count));
			end
			send_request(fn, random_word(), position);
		end
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	// The block fills its pipeline and has to stall the request channel.
	task automatic test_output_stall();
		req_idle_en = 1'b0;
		rsp_hold_cycles = 80;
		test_random_traffic(30);
		req_idle_en = 1'b1;
	endtask

	// The sender stops until every outstanding response has come back, and
	// then resumes from a fully drained block.
	task automatic test_drain_pause();
		test_random_traffic(10);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		test_random_traffic(10);
	endtask

	// ------------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------------

	initial begin
		int waited;
		int kinds;
		clk = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FN_CLEAR;
		req_ch.value = '0;
		req_ch.position = '0;
		req_idle_en = 1'b1;
		rsp_idle_en = 1'b1;
		rsp_hold_cycles = 0;
		shadow_count = 0;
		failures = 0;
		requests_sent = 0;
		results_seen = 0;
		peak_count = 0;
		status_tally = '{default: 0};
		func_tally = '{default: 0};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_edge_positions();
		test_full_list();
		test_random_traffic(150);
		test_output_stall();
		test_drain_pause();
		test_random_traffic(80);

		// The closing stretch runs with both channels at full rate.
		req_idle_en = 1'b0;
		rsp_idle_en = 1'b0;
		test_random_traffic(80);
		req_ch.valid <= 1'b0;

		// Wait for the last responses. The extra wait after that would catch any
		// response without a request.
		waited = 0;
		while (pending_results.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected responses never arrived", pending_results.size());
			failures++;
		end

		kinds = 0;
		foreach (func_tally[k]) begin
			if (func_tally[k] != 0) begin
				kinds++;
			end
		end
		$display("Run summary: %0d requests over %0d of 8 request kinds, %0d responses, peak fill %0d.",
			requests_sent, kinds, results_seen, peak_count);
		$display("Outcomes: %0d ok, %0d full, %0d empty, %0d out of range; long stall and drain pause done.",
			status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
			status_tally[ST_RANGE]);
		if (failures == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run, in which every request
	// meets the longest gap on both sides.
	initial begin
		#400000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/ils_pkg.sv
rtl/ils_if.sv
rtl/ils_decode.sv
rtl/ils_store.sv
rtl/indexed_list_store_core.sv
rtl/ils_checker.sv
bench/indexed_list_store_core_tb.sv
